/* hdl/tnct_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnct_pkg: shared types for the top-N count table
// Request codes, result source selects and the command and status bundles
// that join the controller and the datapath.
// ----------------------------------------------------------------------------
package tnct_pkg;

    // Request command codes.
    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // Source of the fields loaded into the output register.
    typedef enum logic [1:0] {
        SRC_ZERO  = 2'd0,
        SRC_TOUCH = 2'd1,
        SRC_READ  = 2'd2
    } res_src_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     cap_req;     // capture the request fields
        logic     clr_start;   // restart the sweep counter
        logic     clr_write;   // write zero at the sweep counter and advance
        logic     srch_start;  // read entry 0, counter to 0
        logic     srch_step;   // read next entry, counter advances
        logic     hit_load;    // matched entry: hold it with the amount added
        logic     new_load;    // replace the last entry with the request pair
        logic     bub_issue;   // read the entry in front of the hole
        logic     bub_shift;   // move the entry in front back into the hole
        logic     final_write; // write the held entry into the hole
        logic     rd_issue;    // read the entry at the request index
        logic     load_out;    // load the output register
        res_src_t out_src;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] req_cmd;
        logic       hit;       // entry read holds the request key
        logic       last_gt;   // amount beats the count read
        logic       scan_last; // sweep counter is at the last entry
        logic       pos_zero;
        logic       pos_one;
        logic       bub_gt;    // held count beats the count read
        logic       idx_ok;    // request index is inside the table
        logic       out_free;  // output register can take a result
    } dp_status_t;

endpackage

/* hdl/top_n_count_table_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_n_count_table_unit: top-N (key, count) frequency table
// Table kept ordered by count, largest first, with add, read and clear.
// ----------------------------------------------------------------------------
// Add makes one memory read per cycle for the key search, then one swap step
// per cycle toward the front. One request is in work at a time; a new one is
// taken while a result waits. After reset a clearing pass zeroes the table,
// with in_ready low until it completes.
module top_n_count_table_unit
#(
    parameter int TABLE_ENTRIES = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          command,
    input  logic signed [31:0]  key,
    input  logic signed [31:0]  amount,
    input  logic [4:0]          index,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                stored,
    output logic [4:0]          rank,
    output logic signed [31:0]  entry_key,
    output logic signed [31:0]  entry_count
);

    tnct_pkg::ctrl_cmd_t   cmd;
    tnct_pkg::dp_status_t  sts;

    // Sequencer.
    tnct_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Table memory and working registers.
    tnct_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .command     (command),
        .key         (key),
        .amount      (amount),
        .index       (index),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .stored      (stored),
        .rank        (rank),
        .entry_key   (entry_key),
        .entry_count (entry_count)
    );

endmodule

/* hdl/tnct_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnct_ctrl: sequencer for the top-N count table
// Steps each request through clearing, searching, bubbling and read-out, and
// hands the result to the output register when it is free.
// ----------------------------------------------------------------------------
module tnct_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  tnct_pkg::dp_status_t  sts,
    output tnct_pkg::ctrl_cmd_t   cmd
);

    typedef enum logic [9:0] {
        S_INIT_CLR  = 10'b00_0000_0001,
        S_IDLE      = 10'b00_0000_0010,
        S_DISPATCH  = 10'b00_0000_0100,
        S_CMD_CLR   = 10'b00_0000_1000,
        S_SRCH      = 10'b00_0001_0000,
        S_BUB_START = 10'b00_0010_0000,
        S_BUB       = 10'b00_0100_0000,
        S_FIN       = 10'b00_1000_0000,
        S_RD        = 10'b01_0000_0000,
        S_RESP      = 10'b10_0000_0000
    } state_t;

    state_t               state_reg, state_next;
    tnct_pkg::res_src_t   src_reg, src_next;

    // State and result source registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT_CLR;
            src_reg   <= tnct_pkg::SRC_ZERO;
        end
        else
        begin
            state_reg <= state_next;
            src_reg   <= src_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        src_next   = src_reg;
        cmd        = '0;
        cmd.out_src = src_reg;
        case (state_reg)
            S_INIT_CLR:
            begin
                cmd.clr_write = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.cap_req = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (sts.req_cmd)
                    tnct_pkg::CMD_ADD:
                    begin
                        cmd.srch_start = 1'b1;
                        state_next     = S_SRCH;
                    end
                    tnct_pkg::CMD_READ:
                    begin
                        cmd.rd_issue = 1'b1;
                        state_next   = S_RD;
                    end
                    tnct_pkg::CMD_CLEAR:
                    begin
                        cmd.clr_start = 1'b1;
                        state_next    = S_CMD_CLR;
                    end
                    default:
                    begin
                        src_next   = tnct_pkg::SRC_ZERO;
                        state_next = S_RESP;
                    end
                endcase
            end
            S_CMD_CLR:
            begin
                cmd.clr_write = 1'b1;
                if (sts.scan_last)
                begin
                    src_next   = tnct_pkg::SRC_ZERO;
                    state_next = S_RESP;
                end
            end
            S_SRCH:
            begin
                if (sts.hit)
                begin
                    cmd.hit_load = 1'b1;
                    state_next   = S_BUB_START;
                end
                else if (sts.scan_last)
                begin
                    if (sts.last_gt)
                    begin
                        cmd.new_load = 1'b1;
                        state_next   = S_BUB_START;
                    end
                    else
                    begin
                        src_next   = tnct_pkg::SRC_ZERO;
                        state_next = S_RESP;
                    end
                end
                else
                begin
                    cmd.srch_step = 1'b1;
                end
            end
            S_BUB_START:
            begin
                if (sts.pos_zero)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.bub_issue = 1'b1;
                    state_next    = S_BUB;
                end
            end
            S_BUB:
            begin
                if (sts.bub_gt)
                begin
                    cmd.bub_shift = 1'b1;
                    if (sts.pos_one)
                    begin
                        state_next = S_FIN;
                    end
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                cmd.final_write = 1'b1;
                src_next        = tnct_pkg::SRC_TOUCH;
                state_next      = S_RESP;
            end
            S_RD:
            begin
                src_next   = sts.idx_ok ? tnct_pkg::SRC_READ : tnct_pkg::SRC_ZERO;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT_CLR;
            end
        endcase
    end

endmodule

/* hdl/tnct_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnct_datapath: table memory and working registers
// Holds the (key, count) memory, the request, the entry being moved, the
// sweep and position counters, and the output register.
// ----------------------------------------------------------------------------
module tnct_datapath
#(
    parameter int TABLE_ENTRIES = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  tnct_pkg::ctrl_cmd_t   cmd,
    output tnct_pkg::dp_status_t  sts,
    input  logic [1:0]            command,
    input  logic signed [31:0]    key,
    input  logic signed [31:0]    amount,
    input  logic [4:0]            index,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  stored,
    output logic [4:0]            rank,
    output logic signed [31:0]    entry_key,
    output logic signed [31:0]    entry_count
);

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int IW = (AW > 5) ? AW : 5;
    localparam logic [AW-1:0] LAST = AW'(TABLE_ENTRIES - 1);

    // Table memory: key in the upper half, count in the lower half.
    logic [63:0]    mem [TABLE_ENTRIES];

    logic [1:0]     req_cmd_reg;
    logic [31:0]    req_key_reg;
    logic [31:0]    req_amount_reg;
    logic [4:0]     req_index_reg;
    logic [AW-1:0]  scan_reg, scan_next;
    logic [AW-1:0]  pos_reg, pos_next;
    logic [31:0]    t_key_reg, t_key_next;
    logic [31:0]    t_count_reg, t_count_next;
    logic [31:0]    rd_key_reg;
    logic [31:0]    rd_count_reg;
    logic           out_valid_reg;
    logic           stored_reg;
    logic [4:0]     rank_reg;
    logic [31:0]    out_key_reg;
    logic [31:0]    out_count_reg;

    logic           we;
    logic [AW-1:0]  waddr;
    logic [63:0]    wdata;
    logic           re;
    logic [AW-1:0]  raddr;
    logic [IW-1:0]  idx_wide;
    logic [IW-1:0]  pos_wide;

    assign idx_wide = IW'(req_index_reg);
    assign pos_wide = IW'(pos_reg);

    // Request capture.
    always_ff @(posedge clk)
    begin
        if (cmd.cap_req)
        begin
            req_cmd_reg    <= command;
            req_key_reg    <= key;
            req_amount_reg <= amount;
            req_index_reg  <= index;
        end
    end

    // Write port select.
    always_comb
    begin
        we    = 1'b0;
        waddr = scan_reg;
        wdata = '0;
        if (cmd.clr_write)
        begin
            we    = 1'b1;
            waddr = scan_reg;
            wdata = '0;
        end
        else if (cmd.bub_shift)
        begin
            we    = 1'b1;
            waddr = pos_reg;
            wdata = {rd_key_reg, rd_count_reg};
        end
        else if (cmd.final_write)
        begin
            we    = 1'b1;
            waddr = pos_reg;
            wdata = {t_key_reg, t_count_reg};
        end
    end

    // Read port select.
    always_comb
    begin
        re    = 1'b0;
        raddr = '0;
        if (cmd.srch_start)
        begin
            re    = 1'b1;
            raddr = '0;
        end
        else if (cmd.srch_step)
        begin
            re    = 1'b1;
            raddr = scan_reg + AW'(1);
        end
        else if (cmd.bub_issue)
        begin
            re    = 1'b1;
            raddr = pos_reg - AW'(1);
        end
        else if (cmd.bub_shift)
        begin
            re    = !sts.pos_one;
            raddr = pos_reg - AW'(2);
        end
        else if (cmd.rd_issue)
        begin
            re    = 1'b1;
            raddr = idx_wide[AW-1:0];
        end
    end

    // Memory write.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Memory read with registered data.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rd_key_reg   <= mem[raddr][63:32];
            rd_count_reg <= mem[raddr][31:0];
        end
    end

    // Sweep counter, position and the entry being moved.
    always_comb
    begin
        scan_next    = scan_reg;
        pos_next     = pos_reg;
        t_key_next   = t_key_reg;
        t_count_next = t_count_reg;
        if (cmd.clr_start || cmd.srch_start)
        begin
            scan_next = '0;
        end
        else if (cmd.clr_write || cmd.srch_step)
        begin
            scan_next = scan_reg + AW'(1);
        end
        if (cmd.hit_load)
        begin
            pos_next     = scan_reg;
            t_key_next   = req_key_reg;
            t_count_next = rd_count_reg + req_amount_reg;
        end
        else if (cmd.new_load)
        begin
            pos_next     = LAST;
            t_key_next   = req_key_reg;
            t_count_next = req_amount_reg;
        end
        else if (cmd.bub_shift)
        begin
            pos_next = pos_reg - AW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg <= '0;
        end
        else
        begin
            scan_reg <= scan_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        t_key_reg   <= t_key_next;
        t_count_reg <= t_count_next;
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            case (cmd.out_src)
                tnct_pkg::SRC_TOUCH:
                begin
                    stored_reg    <= 1'b1;
                    rank_reg      <= pos_wide[4:0];
                    out_key_reg   <= t_key_reg;
                    out_count_reg <= t_count_reg;
                end
                tnct_pkg::SRC_READ:
                begin
                    stored_reg    <= 1'b1;
                    rank_reg      <= req_index_reg;
                    out_key_reg   <= rd_key_reg;
                    out_count_reg <= rd_count_reg;
                end
                default:
                begin
                    stored_reg    <= 1'b0;
                    rank_reg      <= '0;
                    out_key_reg   <= '0;
                    out_count_reg <= '0;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign stored      = stored_reg;
    assign rank        = rank_reg;
    assign entry_key   = out_key_reg;
    assign entry_count = out_count_reg;

    // Status to the controller.
    assign sts.req_cmd   = req_cmd_reg;
    assign sts.hit       = (rd_key_reg == req_key_reg);
    assign sts.last_gt   = ($signed(req_amount_reg) > $signed(rd_count_reg));
    assign sts.scan_last = (scan_reg == LAST);
    assign sts.pos_zero  = (pos_reg == '0);
    assign sts.pos_one   = (pos_reg == AW'(1));
    assign sts.bub_gt    = ($signed(t_count_reg) > $signed(rd_count_reg));
    assign sts.idx_ok    = (idx_wide <= IW'(TABLE_ENTRIES - 1));
    assign sts.out_free  = !out_valid_reg || out_ready;

    // The search never steps past the last entry.
    a_srch_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.srch_step |-> !sts.scan_last)
        else $error("search stepped past the last entry");

    // An entry moves back only from a nonzero position and only when beaten.
    a_shift_ok: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.bub_shift |-> (!sts.pos_zero && sts.bub_gt))
        else $error("bubble shift without a larger held count");

    // A result is never loaded over one that is still waiting.
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> sts.out_free)
        else $error("output register overwritten while pending");

    // After a move back the position has dropped by one.
    a_pos_dec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.bub_shift |=> (pos_reg == $past(pos_reg) - AW'(1)))
        else $error("position did not follow the bubble shift");

endmodule
